### design/rbf_pkg.sv
// ----------------------------------------------------------------------------
// rbf_pkg
// shared types and constants for the ring buffer byte fifo
// ----------------------------------------------------------------------------
`default_nettype none

package rbf_pkg;

	// free-running pointer width, holds twice the largest store depth
	localparam int PTR_W = 7;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 7;

	// request kinds on the input tuser
	localparam logic REQ_PUT = 1'b0;
	localparam logic REQ_GET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT_OK,
		ST_PUT_DROP,
		ST_GET_DATA,
		ST_GET_NONE
	} rbf_state_t;

	// controller to datapath
	typedef struct packed {
		logic put_wr;    // store the byte and bump the write pointer
		logic get_load;  // load the byte count for a get
		logic rd_adv;    // one byte taken, bump read pointer
		logic emit_data; // a stored byte is on the output
	} rbf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic get_empty; // get would yield no byte
		logic cnt_last;  // byte on the output is the final one of the get
	} rbf_stat_t;

endpackage

`default_nettype wire

### design/rbf_datapath.sv
// ----------------------------------------------------------------------------
// rbf_datapath
// ring store, free-running pointers, byte count and registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_datapath #(
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rbf_pkg::rbf_cmd_t          cmd,
	input  wire logic [rbf_pkg::BYTE_W-1:0] write_byte,
	input  wire logic [rbf_pkg::LEN_W-1:0]  read_length,
	output rbf_pkg::rbf_stat_t              stat,
	output logic [rbf_pkg::BYTE_W-1:0]      read_byte,
	output logic [rbf_pkg::PTR_W-1:0]       fill_level
);
	import rbf_pkg::*;

	// store depth is DEPTH rounded up to a power of two, and at least two
	localparam int EFF = (DEPTH <= 2) ? 2 : (1 << $clog2(DEPTH));
	localparam int AW = $clog2(EFF);
	localparam logic [PTR_W-1:0] EFF_P = PTR_W'(EFF);

	logic [BYTE_W-1:0] mem [EFF];
	logic [BYTE_W-1:0] rd_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  fill;
	logic [PTR_W-1:0]  rp_nxt;
	logic [LEN_W-1:0]  get_n;
	logic [AW-1:0]     rd_addr;

	assign fill    = wp_q - rp_q;
	assign rp_nxt  = rp_q + PTR_W'(1);
	assign get_n   = (read_length < LEN_W'(fill)) ? read_length : LEN_W'(fill);
	// look one entry ahead while a byte is taken so the next is ready in time
	assign rd_addr = cmd.rd_adv ? rp_nxt[AW-1:0] : rp_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.put_wr) begin
			mem[wp_q[AW-1:0]] <= write_byte;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.put_wr) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (cmd.get_load) begin
				cnt_q <= get_n;
			end else if (cmd.rd_adv) begin
				cnt_q <= cnt_q - LEN_W'(1);
			end
			if (cmd.rd_adv) begin
				rp_q <= rp_nxt;
			end
		end
	end

	always_comb begin
		stat.full      = (fill >= EFF_P);
		stat.get_empty = (get_n == '0);
		stat.cnt_last  = (cnt_q == LEN_W'(1));
	end

	assign read_byte  = cmd.emit_data ? rd_q : '0;
	assign fill_level = cmd.emit_data ? (fill - PTR_W'(1)) : fill;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= EFF_P)
		else $error("fill level beyond store depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_wr |-> !stat.full)
		else $error("write into a full store");

	a_read_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_adv |-> (cnt_q != '0) && (fill != '0))
		else $error("read with no byte left");

endmodule

`default_nettype wire

### design/rbf_ctrl.sv
// ----------------------------------------------------------------------------
// rbf_ctrl
// request sequencer: takes one request, then emits its results
// ----------------------------------------------------------------------------
`default_nettype none

module rbf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic               req_type,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic                    last,
	output logic                    byte_valid,
	output logic                    accepted,
	output rbf_pkg::rbf_cmd_t       cmd,
	input  wire rbf_pkg::rbf_stat_t stat
);
	import rbf_pkg::*;

	rbf_state_t state_q;
	rbf_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		last       = 1'b1;
		byte_valid = 1'b0;
		accepted   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (req_type == REQ_PUT) begin
						cmd.put_wr = !stat.full;
						state_d    = stat.full ? ST_PUT_DROP : ST_PUT_OK;
					end else begin
						cmd.get_load = 1'b1;
						state_d      = stat.get_empty ? ST_GET_NONE : ST_GET_DATA;
					end
				end
			end
			ST_PUT_OK: begin
				m_tvalid = 1'b1;
				accepted = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			ST_PUT_DROP, ST_GET_NONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			ST_GET_DATA: begin
				m_tvalid      = 1'b1;
				byte_valid    = 1'b1;
				last          = stat.cnt_last;
				cmd.emit_data = 1'b1;
				if (m_tready) begin
					cmd.rd_adv = 1'b1;
					if (stat.cnt_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while a result is pending");

	a_get_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GET_DATA && m_tready && stat.cnt_last) |=> state_q == ST_IDLE)
		else $error("get did not end after its last byte");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result withdrawn before it was taken");

endmodule

`default_nettype wire

### design/ring_buffer_byte_fifo_unit.sv
// ----------------------------------------------------------------------------
// ring_buffer_byte_fifo_unit
// byte fifo over a power-of-two ring store with free-running pointers
// ----------------------------------------------------------------------------
//  port group   dir   payload
//  s_*          in    request: put one byte or get up to read_length bytes
//  m_*          out   result: one per put, one per byte (or one empty) per get
//
//  a put is accepted, then its result is held until taken
//  a get is accepted, then yields one byte per cycle while m_tready is
//  high, from the single registered read port of the ring store
//  results stall on m_tready with no loss; no request is taken meanwhile
//  reset clears the pointers, the byte count and the state; the store needs
//  no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_byte_fifo_unit #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // write_byte[7:0], read_length[14:8], zero
	input  wire logic        s_tuser,  // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // read_byte[7:0], fill_level[14:8], zero
	output logic [1:0]       m_tuser,  // byte_valid, accepted
	output logic             m_tlast
);
	import rbf_pkg::*;

	rbf_cmd_t          cmd;
	rbf_stat_t         stat;
	logic              byte_valid;
	logic              accepted;
	logic [BYTE_W-1:0] read_byte;
	logic [PTR_W-1:0]  fill_level;

	rbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.req_type  (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.last      (m_tlast),
		.byte_valid(byte_valid),
		.accepted  (accepted),
		.cmd       (cmd),
		.stat      (stat)
	);

	rbf_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.write_byte (s_tdata[7:0]),
		.read_length(s_tdata[14:8]),
		.stat       (stat),
		.read_byte  (read_byte),
		.fill_level (fill_level)
	);

	assign m_tdata = {1'b0, fill_level, read_byte};
	assign m_tuser = {accepted, byte_valid};

endmodule

`default_nettype wire
